// File: src/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg: shared types, constants and tables of the RGB LED effect engine
// Holds the configuration, state and result records, the named colour table
// and the rainbow phase table used by the update logic and the top level.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Level resolution of the LED channels (4 to 16 bits).
    localparam int LEVEL_BITS = 8;

    localparam logic [LEVEL_BITS-1:0] LMAX  = '1;
    localparam logic [LEVEL_BITS-1:0] LHALF = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    // Pulse effect constants.
    localparam logic [31:0] PULSE_FLOOR      = 32'd20;
    localparam logic [31:0] PULSE_RESTART    = 32'd21;
    localparam logic [31:0] PULSE_LOW_DWELL  = 32'd250;
    localparam logic [31:0] PULSE_HIGH_DWELL = 32'd150;
    localparam logic [31:0] PULSE_FRAME      = 32'd10;

    // Blink edges relative to the start time.
    localparam logic [31:0] BLINK_ON_MS  = 32'd150;
    localparam logic [31:0] BLINK_OFF_MS = 32'd300;

    // Limits on the random inputs.
    localparam logic [4:0]  JITTER_MAX = 5'd19;
    localparam logic [4:0]  FRAME_MIN  = 5'd10;
    localparam logic [4:0]  FRAME_MAX  = 5'd19;
    localparam logic [10:0] DWELL_MIN  = 11'd500;
    localparam logic [10:0] DWELL_MAX  = 11'd1999;
    localparam logic [7:0]  PAUSE_MAX  = 8'd69;

    localparam logic [3:0] RB_LAST_PHASE = 4'd12;

    // Effect codes.
    localparam logic [2:0] MODE_STATIC  = 3'd0;
    localparam logic [2:0] MODE_RAINBOW = 3'd1;
    localparam logic [2:0] MODE_FADE    = 3'd2;
    localparam logic [2:0] MODE_PULSE   = 3'd3;
    localparam logic [2:0] MODE_BLINK   = 3'd4;

    // Colour codes with special meaning.
    localparam logic [3:0] COLOR_OFF    = 4'd11;
    localparam logic [3:0] COLOR_CUSTOM = 4'd12;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_EFFECT_MODE    = 3'd0,
        REG_CHANNEL_MASK   = 3'd1,
        REG_NAMED_COLOR    = 3'd2,
        REG_DRIVE_POLARITY = 3'd3,
        REG_CUSTOM_RED     = 3'd4,
        REG_CUSTOM_GREEN   = 3'd5,
        REG_CUSTOM_BLUE    = 3'd6
    } reg_index_t;

    typedef logic [2:0][LEVEL_BITS-1:0] level_vec_t;
    typedef logic [2:0][7:0]            rgb8_t;

    typedef struct packed {
        logic [2:0] effect_mode;
        logic [2:0] channel_mask;
        logic [3:0] named_color;
        logic       drive_polarity;
        logic [7:0] custom_red;
        logic [7:0] custom_green;
        logic [7:0] custom_blue;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [4:0]  step_jitter;
        logic [4:0]  frame_wait;
        logic [10:0] dwell_time;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_drive;
        logic [7:0] green_drive;
        logic [7:0] blue_drive;
        logic       driven;
        logic [6:0] pause_ms;
    } result_t;

    typedef struct packed {
        level_vec_t      levels;
        logic [2:0]      rising;
        logic [2:0]      dwell_armed;
        logic [2:0][31:0] dwell_deadline;
        logic            frame_armed;
        logic [31:0]     frame_deadline;
        logic [3:0]      rainbow_phase;
    } state_t;

    // One rainbow phase: channel, direction, bound codes, pause at its end.
    typedef struct packed {
        logic [1:0] chan;
        logic       up;
        logic [1:0] lo_code;
        logic [1:0] hi_code;
        logic [5:0] pause;
    } rb_entry_t;

    typedef struct packed {
        logic                  adv;
        logic [1:0]            chan;
        logic [LEVEL_BITS-1:0] level;
        logic [5:0]            pause;
    } rb_res_t;

    function automatic rb_entry_t rb_entry(input logic [3:0] p);
        rb_entry_t e;
        case (p)
            4'd0:    e = '{2'd0, 1'b1, 2'd0, 2'd2, 6'd25};
            4'd1:    e = '{2'd1, 1'b1, 2'd0, 2'd1, 6'd50};
            4'd2:    e = '{2'd1, 1'b1, 2'd1, 2'd2, 6'd50};
            4'd3:    e = '{2'd0, 1'b0, 2'd1, 2'd2, 6'd5};
            4'd4:    e = '{2'd0, 1'b0, 2'd0, 2'd1, 6'd25};
            4'd5:    e = '{2'd2, 1'b1, 2'd0, 2'd1, 6'd5};
            4'd6:    e = '{2'd2, 1'b1, 2'd1, 2'd2, 6'd5};
            4'd7:    e = '{2'd1, 1'b0, 2'd1, 2'd2, 6'd5};
            4'd8:    e = '{2'd1, 1'b0, 2'd0, 2'd1, 6'd50};
            4'd9:    e = '{2'd0, 1'b1, 2'd0, 2'd1, 6'd25};
            4'd10:   e = '{2'd0, 1'b1, 2'd1, 2'd2, 6'd25};
            4'd11:   e = '{2'd2, 1'b0, 2'd1, 2'd2, 6'd5};
            4'd12:   e = '{2'd2, 1'b0, 2'd0, 2'd1, 6'd25};
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] rb_bound(input logic [1:0] code);
        logic [LEVEL_BITS-1:0] b;
        case (code)
            2'd0:    b = '0;
            2'd1:    b = LHALF;
            default: b = LMAX;
        endcase
        return b;
    endfunction

    // Evaluates rainbow phase p: either steps its channel or finishes.
    function automatic rb_res_t rb_run(input logic [3:0] p, input level_vec_t lv);
        rb_entry_t             e;
        logic [LEVEL_BITS-1:0] lo;
        logic [LEVEL_BITS-1:0] hi;
        logic [LEVEL_BITS-1:0] l;
        rb_res_t               r;
        e       = rb_entry(p);
        lo      = rb_bound(e.lo_code);
        hi      = rb_bound(e.hi_code);
        l       = lv[e.chan];
        r.chan  = e.chan;
        r.level = l;
        r.adv   = 1'b1;
        r.pause = e.pause;
        if (e.up && l >= lo && l < hi) begin
            r.level = l + 1'b1;
            r.adv   = 1'b0;
            r.pause = '0;
        end else if (!e.up && l > lo && l <= hi) begin
            r.level = l - 1'b1;
            r.adv   = 1'b0;
            r.pause = '0;
        end
        return r;
    endfunction

    // Named colours, listed in blue, green, red order (index 0 is red); unknown codes are off.
    function automatic rgb8_t named_rgb(input logic [3:0] idx);
        rgb8_t c;
        case (idx)
            4'd0:    c = {8'd255, 8'd255, 8'd255};
            4'd1:    c = {8'd0,   8'd0,   8'd255};
            4'd2:    c = {8'd0,   8'd255, 8'd0};
            4'd3:    c = {8'd255, 8'd0,   8'd0};
            4'd4:    c = {8'd0,   8'd255, 8'd255};
            4'd5:    c = {8'd0,   8'd150, 8'd255};
            4'd6:    c = {8'd255, 8'd0,   8'd150};
            4'd7:    c = {8'd220, 8'd255, 8'd0};
            4'd8:    c = {8'd70,  8'd70,  8'd70};
            4'd9:    c = {8'd72,  8'd54,  8'd176};
            4'd10:   c = {8'd255, 8'd0,   8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] fit_level(input logic [7:0] v);
        logic [23:0] w;
        w = {16'b0, v};
        return w[LEVEL_BITS-1:0];
    endfunction

    function automatic logic [31:0] widen(input logic [LEVEL_BITS-1:0] l);
        logic [LEVEL_BITS+31:0] w;
        w = {32'b0, l};
        return w[31:0];
    endfunction

    function automatic logic [7:0] to_drive(input logic [LEVEL_BITS-1:0] l,
                                            input logic                  pol);
        logic [LEVEL_BITS-1:0] d;
        logic [LEVEL_BITS+7:0] w;
        d = pol ? l : (LMAX - l);
        w = {8'b0, d};
        return w[7:0];
    endfunction

endpackage

// File: src/rle_step.sv
// ----------------------------------------------------------------------------
// rle_step: one LED update
// Combinational update of the effect state for one request, producing the
// next state and the result record.
// ----------------------------------------------------------------------------
module rle_step (
    input  rle_pkg::cfg_t     cfg,
    input  rle_pkg::in_item_t item,
    input  rle_pkg::state_t   st,
    output rle_pkg::state_t   st_next,
    output rle_pkg::result_t  res
);

    rle_pkg::rb_res_t rb0;
    rle_pkg::rb_res_t rb1;
    rle_pkg::rb_res_t rbp;

    assign rb0 = rle_pkg::rb_run(4'd0, st.levels);
    assign rb1 = rle_pkg::rb_run(4'd1, st.levels);
    assign rbp = rle_pkg::rb_run(st.rainbow_phase, st.levels);

    always_comb
    begin
        logic [4:0]                     jit;
        logic [4:0]                     fw;
        logic [10:0]                    dw;
        logic [31:0]                    now;
        logic                           wr;
        rle_pkg::level_vec_t            wl;
        rle_pkg::level_vec_t            named;
        rle_pkg::rgb8_t                 tab;
        logic [7:0]                     pause;
        logic [31:0]                    fd;
        logic [31:0]                    dd;
        logic [31:0]                    add;
        logic [31:0]                    lw;
        logic                           fade;
        logic                           act;
        logic [rle_pkg::LEVEL_BITS-1:0] l;

        now = item.now_ms;
        jit = (item.step_jitter > rle_pkg::JITTER_MAX) ? rle_pkg::JITTER_MAX
                                                       : item.step_jitter;
        fw  = (item.frame_wait < rle_pkg::FRAME_MIN) ? rle_pkg::FRAME_MIN :
              (item.frame_wait > rle_pkg::FRAME_MAX) ? rle_pkg::FRAME_MAX :
              item.frame_wait;
        dw  = (item.dwell_time < rle_pkg::DWELL_MIN) ? rle_pkg::DWELL_MIN :
              (item.dwell_time > rle_pkg::DWELL_MAX) ? rle_pkg::DWELL_MAX :
              item.dwell_time;

        tab = rle_pkg::named_rgb(cfg.named_color);
        if (cfg.named_color == rle_pkg::COLOR_CUSTOM) begin
            named[0] = rle_pkg::fit_level(cfg.custom_red);
            named[1] = rle_pkg::fit_level(cfg.custom_green);
            named[2] = rle_pkg::fit_level(cfg.custom_blue);
        end else begin
            for (int c = 0; c < 3; c++) begin
                named[c] = rle_pkg::fit_level(tab[c]);
            end
        end

        st_next = st;
        wr      = 1'b0;
        wl      = st.levels;
        pause   = '0;
        fade    = (cfg.effect_mode == rle_pkg::MODE_FADE);
        fd      = '0;
        dd      = '0;
        add     = '0;
        lw      = '0;
        act     = 1'b0;
        l       = '0;

        case (cfg.effect_mode)
            rle_pkg::MODE_STATIC:
            begin
                wr             = 1'b1;
                wl             = named;
                st_next.levels = named;
            end
            rle_pkg::MODE_RAINBOW:
            begin
                wr    = 1'b1;
                pause = {3'b0, jit};
                if (st.rainbow_phase == 4'd0) begin
                    if (rb0.adv) begin
                        // Phase 0 finished: phase 1 runs in the same update.
                        pause = pause + {2'b0, rb0.pause} + {2'b0, rb1.pause};
                        st_next.levels[rb1.chan] = rb1.level;
                        st_next.rainbow_phase    = rb1.adv ? 4'd2 : 4'd1;
                    end else begin
                        st_next.levels[rb0.chan] = rb0.level;
                    end
                end else if (st.rainbow_phase <= rle_pkg::RB_LAST_PHASE) begin
                    pause                    = pause + {2'b0, rbp.pause};
                    st_next.levels[rbp.chan] = rbp.level;
                    if (rbp.adv) begin
                        st_next.rainbow_phase = st.rainbow_phase + 4'd1;
                    end
                end else begin
                    st_next.rainbow_phase = '0;
                end
                if (pause > rle_pkg::PAUSE_MAX) begin
                    pause = rle_pkg::PAUSE_MAX;
                end
            end
            rle_pkg::MODE_FADE, rle_pkg::MODE_PULSE:
            begin
                fd = st.frame_armed ? st.frame_deadline
                                    : now + (fade ? {27'b0, fw} : rle_pkg::PULSE_FRAME);
                st_next.frame_deadline = fd;
                st_next.frame_armed    = 1'b1;
                if (fd <= now) begin
                    wr                  = 1'b1;
                    st_next.frame_armed = 1'b0;
                    for (int c = 0; c < 3; c++) begin
                        l  = st.levels[c];
                        lw = rle_pkg::widen(l);
                        act = fade ? cfg.channel_mask[c]
                                   : (cfg.channel_mask == (3'b001 << c));
                        if (act) begin
                            if ((fade && l != '0 && l != rle_pkg::LMAX) ||
                                (!fade && lw > rle_pkg::PULSE_FLOOR &&
                                 l != rle_pkg::LMAX)) begin
                                st_next.levels[c] = st.rising[c] ? l + 1'b1 : l - 1'b1;
                            end else begin
                                add = fade ? {21'b0, dw} :
                                      (lw <= rle_pkg::PULSE_FLOOR) ?
                                      rle_pkg::PULSE_LOW_DWELL : rle_pkg::PULSE_HIGH_DWELL;
                                dd  = st.dwell_armed[c] ? st.dwell_deadline[c] : now + add;
                                st_next.dwell_deadline[c] = dd;
                                st_next.dwell_armed[c]    = 1'b1;
                                if (dd <= now) begin
                                    st_next.dwell_armed[c] = 1'b0;
                                    if (fade) begin
                                        st_next.levels[c] = (l == '0) ? {{(rle_pkg::LEVEL_BITS-1){1'b0}}, 1'b1}
                                                                      : rle_pkg::LMAX - 1'b1;
                                        st_next.rising[c] = (l == '0);
                                    end else if (lw <= rle_pkg::PULSE_FLOOR) begin
                                        st_next.levels[c] =
                                            rle_pkg::PULSE_RESTART[rle_pkg::LEVEL_BITS-1:0];
                                        st_next.rising[c] = 1'b1;
                                    end else begin
                                        st_next.levels[c] = rle_pkg::LMAX - 1'b1;
                                        st_next.rising[c] = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            rle_pkg::MODE_BLINK:
            begin
                fd = st.frame_armed ? st.frame_deadline : now;
                st_next.frame_deadline = fd;
                st_next.frame_armed    = 1'b1;
                if (fd + rle_pkg::BLINK_ON_MS <= now) begin
                    wr             = 1'b1;
                    wl             = named;
                    st_next.levels = named;
                end
                // The off edge wins when both edges fall in one update.
                if (fd + rle_pkg::BLINK_OFF_MS <= now) begin
                    wr                  = 1'b1;
                    wl                  = '0;
                    st_next.levels      = '0;
                    st_next.frame_armed = 1'b0;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase

        res.driven      = wr;
        res.red_drive   = wr ? rle_pkg::to_drive(wl[0], cfg.drive_polarity) : 8'd0;
        res.green_drive = wr ? rle_pkg::to_drive(wl[1], cfg.drive_polarity) : 8'd0;
        res.blue_drive  = wr ? rle_pkg::to_drive(wl[2], cfg.drive_polarity) : 8'd0;
        res.pause_ms    = pause[6:0];
    end

endmodule

// File: src/rgb_led_effect_engine_top.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_top: RGB LED effect engine
// Takes timed update requests, runs the configured effect (static, rainbow,
// random fade, pulse or blink) and returns the channel drive levels.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Handshake                  | Contents
// ----------+-----------+----------------------------+---------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready| update request
// m_axis    | out       | m_axis_tvalid/m_axis_tready| drive levels, pause, flag
// cfg       | in        | cfg_valid/cfg_ready        | register index and value
//
// One update request is accepted per clock while s_axis_tready is high. A
// request waits in the input register until the result register is free or
// being emptied; then the state update commits and the result register loads.
// s_axis_tready is low only while both the input register and the result
// register hold data and m_axis_tready is low. The reset (rst_n, asynchronous,
// active low) restores the register defaults and clears all effect state.
//
module rgb_led_effect_engine_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [36:32] step_jitter, [41:37] frame_wait,
    // [52:42] dwell_time, [55:53] zero
    input  logic [55:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] red_drive, [15:8] green_drive, [23:16] blue_drive,
    // [30:24] pause_ms, [31] zero
    output logic [31:0] m_axis_tdata,
    // [0] driven
    output logic        m_axis_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    rle_pkg::cfg_t     cfg_reg;
    rle_pkg::state_t   state_reg;
    rle_pkg::state_t   state_next;
    rle_pkg::in_item_t in_data_reg;
    logic              in_valid_reg;
    rle_pkg::result_t  out_data_reg;
    rle_pkg::result_t  out_data_next;
    logic              out_valid_reg;
    logic              advance;

    // The input stage moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // Configuration registers; they are to be written only while the engine is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.effect_mode    <= rle_pkg::MODE_STATIC;
            cfg_reg.channel_mask   <= 3'b111;
            cfg_reg.named_color    <= rle_pkg::COLOR_OFF;
            cfg_reg.drive_polarity <= 1'b0;
            cfg_reg.custom_red     <= '0;
            cfg_reg.custom_green   <= '0;
            cfg_reg.custom_blue    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rle_pkg::REG_EFFECT_MODE:    cfg_reg.effect_mode    <= cfg_data[2:0];
                rle_pkg::REG_CHANNEL_MASK:   cfg_reg.channel_mask   <= cfg_data[2:0];
                rle_pkg::REG_NAMED_COLOR:    cfg_reg.named_color    <= cfg_data[3:0];
                rle_pkg::REG_DRIVE_POLARITY: cfg_reg.drive_polarity <= cfg_data[0];
                rle_pkg::REG_CUSTOM_RED:     cfg_reg.custom_red     <= cfg_data;
                rle_pkg::REG_CUSTOM_GREEN:   cfg_reg.custom_green   <= cfg_data;
                rle_pkg::REG_CUSTOM_BLUE:    cfg_reg.custom_blue    <= cfg_data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Input register: valid flag under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg.now_ms      <= s_axis_tdata[31:0];
            in_data_reg.step_jitter <= s_axis_tdata[36:32];
            in_data_reg.frame_wait  <= s_axis_tdata[41:37];
            in_data_reg.dwell_time  <= s_axis_tdata[52:42];
        end
    end

    rle_step u_step (
        .cfg     (cfg_reg),
        .item    (in_data_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (out_data_next)
    );

    // Effect state is committed once per request, as it leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg.pause_ms, out_data_reg.blue_drive,
                            out_data_reg.green_drive, out_data_reg.red_drive};
    assign m_axis_tuser  = out_data_reg.driven;

    // An update that drives nothing reports zero levels and no pause.
    a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("undriven result carries non-zero data");

    // The rainbow pause is saturated.
    a_pause_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:24] <= 7'd69)
        else $error("pause above its limit");

    // The rainbow walk never goes beyond its wrap phase.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rainbow_phase <= 4'd13)
        else $error("rainbow phase out of range");

    // A request leaving the input stage always lands in the result register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after input stage advanced");

endmodule

// File: dv/tb_rgb_led_effect_engine_top.sv
// ----------------------------------------------------------------------------
// tb_rgb_led_effect_engine_top: self-checking bench for the LED effect engine
// Drives timed update requests and register writes into the engine, keeps an
// independent model of the effect state and compares every returned drive
// word with the model's prediction. A short directed part covers colours,
// unknown effects, the rainbow double step, time wrap and the blink edges; a
// long random part then walks all effects with random timing and stalls.
// ----------------------------------------------------------------------------
module tb_rgb_led_effect_engine_top;

    // Model constants.
    localparam logic [7:0]  LVL_ZERO       = 8'd0;
    localparam logic [7:0]  LVL_HALF       = 8'd128;
    localparam logic [7:0]  LVL_FULL       = 8'd255;
    localparam logic [7:0]  FLOOR_LVL      = 8'd20;
    localparam logic [31:0] FLOOR_DWELL    = 32'd250;
    localparam logic [31:0] TOP_DWELL      = 32'd150;
    localparam logic [31:0] PULSE_TICK     = 32'd10;
    localparam logic [31:0] BLINK_ON       = 32'd150;
    localparam logic [31:0] BLINK_OFF      = 32'd300;
    localparam logic [4:0]  JIT_CAP        = 5'd19;
    localparam logic [4:0]  FRAME_LO       = 5'd10;
    localparam logic [4:0]  FRAME_HI       = 5'd19;
    localparam logic [10:0] DWELL_LO       = 11'd500;
    localparam logic [10:0] DWELL_HI       = 11'd1999;
    localparam int unsigned PAUSE_CAP      = 69;
    localparam logic [2:0]  MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;

    localparam int unsigned TOTAL_REQUESTS = 1850;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS    = 30;

    typedef struct packed {
        logic [1:0] ch;
        logic       up;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [5:0] rest;
    } leg_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    rgb_led_effect_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Effect model: its own copy of the registers and the effect state.
    // ------------------------------------------------------------------
    rle_pkg::cfg_t    cfg;
    logic [7:0]       lvl [3];
    logic             rise [3];
    logic             dwell_on [3];
    logic [31:0]      dwell_end [3];
    logic             frame_on;
    logic [31:0]      frame_end;
    logic [3:0]       rb_phase;
    rle_pkg::result_t upd;

    rle_pkg::result_t expected_drive_q [$];
    rle_pkg::result_t seen_drive;
    rle_pkg::result_t want_drive;
    int unsigned      mismatch_count;
    int unsigned      requests_sent;
    logic [31:0]      clock_ms;

    // Stall control shared by the stimulus and the two handshake processes.
    logic        src_gaps;
    logic        sink_stalls;
    logic        hold_request;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned quiet_cycles;

    function automatic logic [23:0] colour_levels(input logic [3:0] code);
        logic [23:0] rgb;
        case (code)
            4'd0:    rgb = 24'hFF_FF_FF;
            4'd1:    rgb = 24'hFF_00_00;
            4'd2:    rgb = 24'h00_FF_00;
            4'd3:    rgb = 24'h00_00_FF;
            4'd4:    rgb = 24'hFF_FF_00;
            4'd5:    rgb = 24'hFF_96_00;
            4'd6:    rgb = 24'h96_00_FF;
            4'd7:    rgb = 24'h00_FF_DC;
            4'd8:    rgb = 24'h46_46_46;
            4'd9:    rgb = 24'hB0_36_48;
            4'd10:   rgb = 24'hFF_00_FF;
            default: rgb = 24'h00_00_00;
        endcase
        return rgb;
    endfunction

    // Writes the three channel levels and the drive word derived from them.
    function automatic void show_levels(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        lvl[0] = r;
        lvl[1] = g;
        lvl[2] = b;
        upd.red_drive   = cfg.drive_polarity ? r : LVL_FULL - r;
        upd.green_drive = cfg.drive_polarity ? g : LVL_FULL - g;
        upd.blue_drive  = cfg.drive_polarity ? b : LVL_FULL - b;
        upd.driven      = 1'b1;
    endfunction

    function automatic void show_colour();
        logic [23:0] rgb;
        if (cfg.named_color == rle_pkg::COLOR_CUSTOM)
            rgb = {cfg.custom_red, cfg.custom_green, cfg.custom_blue};
        else
            rgb = colour_levels(cfg.named_color);
        show_levels(rgb[23:16], rgb[15:8], rgb[7:0]);
    endfunction

    // One rainbow leg: steps its channel, or moves to the next leg and
    // returns the pause that closes it.
    function automatic int unsigned rainbow_leg(input logic [3:0] p);
        leg_t       g;
        logic [7:0] l;
        case (p)
            4'd0:    g = '{2'd0, 1'b1, LVL_ZERO, LVL_FULL, 6'd25};
            4'd1:    g = '{2'd1, 1'b1, LVL_ZERO, LVL_HALF, 6'd50};
            4'd2:    g = '{2'd1, 1'b1, LVL_HALF, LVL_FULL, 6'd50};
            4'd3:    g = '{2'd0, 1'b0, LVL_HALF, LVL_FULL, 6'd5};
            4'd4:    g = '{2'd0, 1'b0, LVL_ZERO, LVL_HALF, 6'd25};
            4'd5:    g = '{2'd2, 1'b1, LVL_ZERO, LVL_HALF, 6'd5};
            4'd6:    g = '{2'd2, 1'b1, LVL_HALF, LVL_FULL, 6'd5};
            4'd7:    g = '{2'd1, 1'b0, LVL_HALF, LVL_FULL, 6'd5};
            4'd8:    g = '{2'd1, 1'b0, LVL_ZERO, LVL_HALF, 6'd50};
            4'd9:    g = '{2'd0, 1'b1, LVL_ZERO, LVL_HALF, 6'd25};
            4'd10:   g = '{2'd0, 1'b1, LVL_HALF, LVL_FULL, 6'd25};
            4'd11:   g = '{2'd2, 1'b0, LVL_HALF, LVL_FULL, 6'd5};
            default: g = '{2'd2, 1'b0, LVL_ZERO, LVL_HALF, 6'd25};
        endcase
        l = lvl[g.ch];
        if (g.up && l >= g.lo && l < g.hi) begin
            lvl[g.ch] = l + 8'd1;
            return 0;
        end
        if (!g.up && l > g.lo && l <= g.hi) begin
            lvl[g.ch] = l - 8'd1;
            return 0;
        end
        rb_phase = p + 4'd1;
        return {26'd0, g.rest};
    endfunction

    function automatic void fade_step(input int c, input logic [31:0] now,
                                      input logic [31:0] dwell);
        logic [7:0] l;
        l = lvl[c];
        if (l > LVL_ZERO && l < LVL_FULL) begin
            lvl[c] = rise[c] ? l + 8'd1 : l - 8'd1;
            return;
        end
        if (!dwell_on[c]) begin
            dwell_end[c] = now + dwell;
            dwell_on[c]  = 1'b1;
        end
        if (dwell_end[c] <= now) begin
            lvl[c]      = (l == LVL_ZERO) ? 8'd1 : LVL_FULL - 8'd1;
            rise[c]     = (l == LVL_ZERO);
            dwell_on[c] = 1'b0;
        end
    endfunction

    // The pulse rests at the floor for the long dwell and at the top for the
    // short one, then restarts just above the floor or just below the top.
    function automatic void pulse_step(input int c, input logic [31:0] now);
        logic [7:0] l;
        l = lvl[c];
        if (l > FLOOR_LVL && l < LVL_FULL) begin
            lvl[c] = rise[c] ? l + 8'd1 : l - 8'd1;
            return;
        end
        if (!dwell_on[c]) begin
            dwell_end[c] = now + ((l <= FLOOR_LVL) ? FLOOR_DWELL : TOP_DWELL);
            dwell_on[c]  = 1'b1;
        end
        if (dwell_end[c] <= now) begin
            if (l <= FLOOR_LVL) begin
                lvl[c]  = FLOOR_LVL + 8'd1;
                rise[c] = 1'b1;
            end else begin
                lvl[c]  = LVL_FULL - 8'd1;
                rise[c] = 1'b0;
            end
            dwell_on[c] = 1'b0;
        end
    endfunction

    function automatic rle_pkg::result_t predict_update(input rle_pkg::in_item_t req);
        logic [31:0] now;
        logic [4:0]  jit;
        logic [4:0]  fw;
        logic [10:0] dw;
        int unsigned pause;
        now = req.now_ms;
        jit = (req.step_jitter > JIT_CAP) ? JIT_CAP : req.step_jitter;
        fw  = (req.frame_wait < FRAME_LO) ? FRAME_LO :
              (req.frame_wait > FRAME_HI) ? FRAME_HI : req.frame_wait;
        dw  = (req.dwell_time < DWELL_LO) ? DWELL_LO :
              (req.dwell_time > DWELL_HI) ? DWELL_HI : req.dwell_time;
        upd   = '0;
        pause = 0;
        case (cfg.effect_mode)
            rle_pkg::MODE_STATIC: show_colour();
            rle_pkg::MODE_RAINBOW:
            begin
                show_levels(lvl[0], lvl[1], lvl[2]);
                pause = {27'd0, jit};
                if (rb_phase == 4'd0)
                begin
                    pause += rainbow_leg(4'd0);
                    if (rb_phase == 4'd1)
                        pause += rainbow_leg(4'd1);
                end
                else if (rb_phase <= rle_pkg::RB_LAST_PHASE)
                    pause += rainbow_leg(rb_phase);
                else
                    rb_phase = 4'd0;
                if (pause > PAUSE_CAP)
                    pause = PAUSE_CAP;
                upd.pause_ms = pause[6:0];
            end
            rle_pkg::MODE_FADE, rle_pkg::MODE_PULSE:
            begin
                if (!frame_on)
                begin
                    frame_end = now + ((cfg.effect_mode == rle_pkg::MODE_FADE) ? {27'd0, fw}
                                                                               : PULSE_TICK);
                    frame_on  = 1'b1;
                end
                if (frame_end <= now)
                begin
                    show_levels(lvl[0], lvl[1], lvl[2]);
                    frame_on = 1'b0;
                    for (int c = 0; c < 3; c++)
                    begin
                        if (cfg.effect_mode == rle_pkg::MODE_FADE)
                        begin
                            if (cfg.channel_mask[c])
                                fade_step(c, now, {21'd0, dw});
                        end
                        else if (cfg.channel_mask == (3'b001 << c))
                            pulse_step(c, now);
                    end
                end
            end
            rle_pkg::MODE_BLINK:
            begin
                // The blink start time lives in the frame deadline.
                if (!frame_on)
                begin
                    frame_end = now;
                    frame_on  = 1'b1;
                end
                if (frame_end + BLINK_ON <= now)
                    show_colour();
                if (frame_end + BLINK_OFF <= now)
                begin
                    show_levels(LVL_ZERO, LVL_ZERO, LVL_ZERO);
                    frame_on = 1'b0;
                end
            end
            default: ;
        endcase
        return upd;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers. Every stimulus task starts and ends at a falling
    // edge; inputs only change there.
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input rle_pkg::in_item_t req);
        if (src_gaps && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, req.dwell_time, req.frame_wait, req.step_jitter,
                         req.now_ms};
        do @(posedge clk); while (!s_axis_tready);
        expected_drive_q.push_back(predict_update(req));
        requests_sent++;
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every prediction is matched.
    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input rle_pkg::reg_index_t idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            rle_pkg::REG_EFFECT_MODE:    cfg.effect_mode    = val[2:0];
            rle_pkg::REG_CHANNEL_MASK:   cfg.channel_mask   = val[2:0];
            rle_pkg::REG_NAMED_COLOR:    cfg.named_color    = val[3:0];
            rle_pkg::REG_DRIVE_POLARITY: cfg.drive_polarity = val[0];
            rle_pkg::REG_CUSTOM_RED:     cfg.custom_red     = val;
            rle_pkg::REG_CUSTOM_GREEN:   cfg.custom_green   = val;
            rle_pkg::REG_CUSTOM_BLUE:    cfg.custom_blue    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Now and then sets the unused upper bits of a narrow register write.
    function automatic logic [7:0] with_spare_bits(input logic [7:0] v,
                                                   input int unsigned w);
        logic [7:0] keep;
        keep = 8'hFF >> (8 - w);
        if ($urandom_range(0, 3) != 0)
            return v & keep;
        return (v & keep) | (8'($urandom()) & ~keep);
    endfunction

    function automatic rle_pkg::in_item_t make_req(input logic [31:0] now,
                                                   input logic [4:0] jit,
                                                   input logic [4:0] fw,
                                                   input logic [10:0] dw);
        rle_pkg::in_item_t req;
        req.now_ms      = now;
        req.step_jitter = jit;
        req.frame_wait  = fw;
        req.dwell_time  = dw;
        return req;
    endfunction

    // Time mostly moves forward by about one frame; sometimes it leaps ahead
    // to run out dwells, jumps anywhere, goes back or sits near the wrap.
    function automatic rle_pkg::in_item_t next_request();
        int unsigned pick;
        logic [4:0]  jit;
        logic [4:0]  fw;
        logic [10:0] dw;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            clock_ms = $urandom();
        else if (pick < 3)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        else if (pick < 5)
            clock_ms = clock_ms - $urandom_range(1, 50);
        else if (pick < 15)
            clock_ms = clock_ms + $urandom_range(100, 2100);
        else
            clock_ms = clock_ms + $urandom_range(0, 24);
        jit = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31))
                                          : 5'($urandom_range(0, 19));
        if ($urandom_range(0, 9) == 0)
            fw = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 9))
                                             : 5'($urandom_range(20, 31));
        else
            fw = 5'($urandom_range(10, 19));
        if ($urandom_range(0, 9) == 0)
            dw = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 499))
                                             : 11'($urandom_range(2000, 2047));
        else
            dw = 11'($urandom_range(500, 1999));
        return make_req(clock_ms, jit, fw, dw);
    endfunction

    // Levels next to the thresholds of the rainbow, fade and pulse.
    function automatic logic [7:0] threshold_level();
        case ($urandom_range(0, 12))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd19;
            3:       return 8'd20;
            4:       return 8'd21;
            5:       return 8'd126;
            6:       return 8'd127;
            7:       return 8'd128;
            8:       return 8'd129;
            9:       return 8'd253;
            10:      return 8'd254;
            11:      return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s is %0d, model has %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker, sink stall generator and watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_drive.red_drive   = m_axis_tdata[7:0];
            seen_drive.green_drive = m_axis_tdata[15:8];
            seen_drive.blue_drive  = m_axis_tdata[23:16];
            seen_drive.pause_ms    = m_axis_tdata[30:24];
            seen_drive.driven      = m_axis_tuser;
            if (expected_drive_q.size() == 0)
                report_mismatch("result with no request pending", 32'd0, 32'd0);
            else
            begin
                want_drive = expected_drive_q.pop_front();
                if (seen_drive.red_drive !== want_drive.red_drive)
                    report_mismatch("red_drive", {24'd0, seen_drive.red_drive},
                                    {24'd0, want_drive.red_drive});
                if (seen_drive.green_drive !== want_drive.green_drive)
                    report_mismatch("green_drive", {24'd0, seen_drive.green_drive},
                                    {24'd0, want_drive.green_drive});
                if (seen_drive.blue_drive !== want_drive.blue_drive)
                    report_mismatch("blue_drive", {24'd0, seen_drive.blue_drive},
                                    {24'd0, want_drive.blue_drive});
                if (seen_drive.pause_ms !== want_drive.pause_ms)
                    report_mismatch("pause_ms", {25'd0, seen_drive.pause_ms},
                                    {25'd0, want_drive.pause_ms});
                if (seen_drive.driven !== want_drive.driven)
                    report_mismatch("driven", {31'd0, seen_drive.driven},
                                    {31'd0, want_drive.driven});
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Register defaults: static effect, colour off, inverted drive.
    task automatic test_reset_defaults();
        send_request(make_req(32'd0, 5'd0, 5'd0, 11'd0));
        send_request(make_req(32'hFFFF_FFFF, 5'd31, 5'd31, 11'd2047));
        wait_results_drained();
    endtask

    // Every colour code, including the custom levels and the unused codes,
    // with the polarity alternating.
    task automatic test_named_colours();
        write_reg(rle_pkg::REG_CUSTOM_RED, 8'd255);
        write_reg(rle_pkg::REG_CUSTOM_GREEN, 8'd0);
        write_reg(rle_pkg::REG_CUSTOM_BLUE, 8'd128);
        for (int code = 0; code < 16; code++)
        begin
            write_reg(rle_pkg::REG_NAMED_COLOR, 8'(code));
            write_reg(rle_pkg::REG_DRIVE_POLARITY, 8'(code % 2));
            send_request(make_req($urandom(), 5'd0, 5'd10, 11'd500));
            wait_results_drained();
        end
    endtask

    // An effect code with no meaning drives nothing and keeps the state.
    task automatic test_unknown_effect();
        write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, MODE_SPARE_HI});
        send_request(make_req(32'd1000, 5'd19, 5'd19, 11'd1999));
        wait_results_drained();
    endtask

    // With red at full and green at half, the first two rainbow legs end in
    // one update and the summed pause saturates.
    task automatic test_rainbow_double_step();
        write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, rle_pkg::MODE_STATIC});
        write_reg(rle_pkg::REG_NAMED_COLOR, {4'd0, rle_pkg::COLOR_CUSTOM});
        write_reg(rle_pkg::REG_CUSTOM_GREEN, 8'd128);
        write_reg(rle_pkg::REG_CUSTOM_BLUE, 8'd0);
        send_request(make_req(32'd0, 5'd0, 5'd10, 11'd500));
        wait_results_drained();
        write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, rle_pkg::MODE_RAINBOW});
        send_request(make_req(32'd0, 5'd31, 5'd10, 11'd500));
        send_request(make_req(32'd0, 5'd0, 5'd10, 11'd500));
        wait_results_drained();
    endtask

    // The frame and dwell deadlines wrap past the top of the time range.
    task automatic test_fade_time_wrap();
        write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, rle_pkg::MODE_FADE});
        write_reg(rle_pkg::REG_CHANNEL_MASK, 8'd7);
        send_request(make_req(32'hFFFF_FFFB, 5'd0, 5'd19, 11'd1999));
        send_request(make_req(32'd5, 5'd0, 5'd10, 11'd500));
        wait_results_drained();
    endtask

    // Blink with the custom colour: a stale start time makes both edges fall
    // in one update, then a fresh start, the on edge and the off edge.
    task automatic test_blink_edges();
        write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, rle_pkg::MODE_BLINK});
        send_request(make_req(32'd1000, 5'd0, 5'd10, 11'd500));
        send_request(make_req(32'd1010, 5'd0, 5'd10, 11'd500));
        send_request(make_req(32'd1170, 5'd0, 5'd10, 11'd500));
        send_request(make_req(32'd1320, 5'd0, 5'd10, 11'd500));
        wait_results_drained();
    endtask

    // The sink holds off for a long stretch while requests keep coming, so
    // the engine fills up and stalls its input.
    task automatic test_output_backpressure();
        write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, rle_pkg::MODE_RAINBOW});
        src_gaps     = 1'b0;
        sink_stalls  = 1'b0;
        hold_request = 1'b1;
        repeat (40)
            send_request(next_request());
        wait_results_drained();
    endtask

    task automatic test_random_effects();
        int unsigned pick;
        logic [2:0]  mode;
        logic [7:0]  mask;
        while (requests_sent < TOTAL_REQUESTS)
        begin
            wait_results_drained();
            src_gaps    = ($urandom_range(0, 2) != 0);
            sink_stalls = ($urandom_range(0, 2) != 0);

            // Load levels next to the thresholds through the static effect,
            // so that later effects reach their turning points quickly.
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(rle_pkg::REG_EFFECT_MODE, {5'd0, rle_pkg::MODE_STATIC});
                write_reg(rle_pkg::REG_NAMED_COLOR, {4'd0, rle_pkg::COLOR_CUSTOM});
                write_reg(rle_pkg::REG_CUSTOM_RED, threshold_level());
                write_reg(rle_pkg::REG_CUSTOM_GREEN, threshold_level());
                write_reg(rle_pkg::REG_CUSTOM_BLUE, threshold_level());
                send_request(next_request());
                wait_results_drained();
            end

            pick = $urandom_range(0, 99);
            if (pick < 8)
                mode = rle_pkg::MODE_STATIC;
            else if (pick < 28)
                mode = rle_pkg::MODE_RAINBOW;
            else if (pick < 53)
                mode = rle_pkg::MODE_FADE;
            else if (pick < 78)
                mode = rle_pkg::MODE_PULSE;
            else if (pick < 94)
                mode = rle_pkg::MODE_BLINK;
            else
                mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));

            if (mode == rle_pkg::MODE_PULSE && $urandom_range(0, 3) != 0)
                mask = 8'd1 << $urandom_range(0, 2);
            else
                mask = 8'($urandom_range(0, 7));

            write_reg(rle_pkg::REG_EFFECT_MODE, with_spare_bits({5'd0, mode}, 3));
            write_reg(rle_pkg::REG_CHANNEL_MASK, with_spare_bits(mask, 3));
            write_reg(rle_pkg::REG_NAMED_COLOR,
                      with_spare_bits(8'($urandom_range(0, 15)), 4));
            write_reg(rle_pkg::REG_DRIVE_POLARITY,
                      with_spare_bits(8'($urandom_range(0, 1)), 1));
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(rle_pkg::REG_CUSTOM_RED, threshold_level());
                write_reg(rle_pkg::REG_CUSTOM_GREEN, threshold_level());
                write_reg(rle_pkg::REG_CUSTOM_BLUE, threshold_level());
            end

            repeat ($urandom_range(20, 80))
                send_request(next_request());
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = rle_pkg::REG_EFFECT_MODE;
        cfg_data       = '0;
        src_gaps       = 1'b1;
        sink_stalls    = 1'b1;
        hold_request   = 1'b0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        requests_sent  = 0;
        clock_ms       = $urandom_range(0, 100000);

        // Model state after reset.
        cfg.effect_mode    = rle_pkg::MODE_STATIC;
        cfg.channel_mask   = 3'b111;
        cfg.named_color    = rle_pkg::COLOR_OFF;
        cfg.drive_polarity = 1'b0;
        cfg.custom_red     = 8'd0;
        cfg.custom_green   = 8'd0;
        cfg.custom_blue    = 8'd0;
        for (int c = 0; c < 3; c++)
        begin
            lvl[c]       = 8'd0;
            rise[c]      = 1'b0;
            dwell_on[c]  = 1'b0;
            dwell_end[c] = 32'd0;
        end
        frame_on  = 1'b0;
        frame_end = 32'd0;
        rb_phase  = 4'd0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_named_colours();
        test_unknown_effect();
        test_rainbow_double_step();
        test_fade_time_wrap();
        test_blink_edges();
        test_output_backpressure();
        test_random_effects();

        // Wait for anything unexpected to show up before the final check.
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && expected_drive_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/rle_pkg.sv
src/rle_step.sv
src/rgb_led_effect_engine_top.sv
dv/tb_rgb_led_effect_engine_top.sv
